[hdl/tksh_pkg.sv]
`default_nettype none
package tksh_pkg;

  // Store geometry
  localparam int KEEP_COUNT = 10;
  localparam int IDX_W      = $clog2(KEEP_COUNT);
  localparam int CNT_W      = $clog2(KEEP_COUNT + 1);

  // Field widths
  localparam int OFFSET_W = 32;
  localparam int SCORE_W  = 16;

  // Command classes passed from front to back
  typedef enum logic {
    CMD_OFFER = 1'b0,
    CMD_FLUSH = 1'b1
  } cmd_t;

  // One kept (offset, score) pair
  typedef struct packed {
    logic [OFFSET_W-1:0] offset;
    logic [SCORE_W-1:0]  score;
  } entry_t;

  // Input transaction
  typedef struct packed {
    logic                mode;
    logic [OFFSET_W-1:0] offset;
    logic [SCORE_W-1:0]  score;
  } in_item_t;

  // Result transaction
  typedef struct packed {
    logic [OFFSET_W-1:0] entry_offset;
    logic [SCORE_W-1:0]  entry_score;
    logic                entry_valid;
    logic                last;
  } out_item_t;

  // Classified command held in the front queue
  typedef struct packed {
    cmd_t   cmd;
    entry_t entry;
  } cmd_item_t;

endpackage
`default_nettype wire

[hdl/tksh_front.sv]
`default_nettype none
module tksh_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_push,
  output logic                     in_full,
  input  wire tksh_pkg::in_item_t  in_item,
  output logic                     cmd_valid,
  output tksh_pkg::cmd_item_t      cmd_item,
  input  wire logic                cmd_take
);
  import tksh_pkg::*;

  localparam int CMDQ_DEPTH = 2;
  localparam int CQ_PW      = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int CQ_CW      = $clog2(CMDQ_DEPTH + 1);
  localparam logic [CQ_PW-1:0] PTR_LAST = CQ_PW'(CMDQ_DEPTH - 1);
  localparam logic [CQ_CW-1:0] FILL_MAX = CQ_CW'(CMDQ_DEPTH);

  cmd_item_t        q_r [CMDQ_DEPTH];
  logic [CQ_PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CQ_PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CQ_CW-1:0] fill_r, fill_nxt;
  logic             push_ok;
  logic             pop_ok;
  cmd_item_t        new_cmd;

  // Classify the incoming transaction
  always_comb begin
    new_cmd.cmd          = in_item.mode ? CMD_FLUSH : CMD_OFFER;
    new_cmd.entry.offset = in_item.offset;
    new_cmd.entry.score  = in_item.score;
  end

  assign in_full   = (fill_r == FILL_MAX);
  assign cmd_valid = (fill_r != '0);
  assign cmd_item  = q_r[rd_ptr_r];
  assign push_ok   = in_push && !in_full;
  assign pop_ok    = cmd_take && cmd_valid;

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push_ok) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + CQ_PW'(1);
    end
    if (pop_ok) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + CQ_PW'(1);
    end
    if (push_ok && !pop_ok) begin
      fill_nxt = fill_r + CQ_CW'(1);
    end else if (pop_ok && !push_ok) begin
      fill_nxt = fill_r - CQ_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Store the classified command
  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_r[wr_ptr_r] <= new_cmd;
    end
  end

endmodule
`default_nettype wire

[hdl/tksh_back.sv]
`default_nettype none
module tksh_back (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cmd_valid,
  input  wire tksh_pkg::cmd_item_t  cmd_item,
  output logic                      cmd_take,
  output logic                      out_empty,
  input  wire logic                 out_pop,
  output tksh_pkg::out_item_t       out_item
);
  import tksh_pkg::*;

  localparam int CH_W = IDX_W + 2;
  localparam logic [CH_W-1:0]  K_CH      = CH_W'(KEEP_COUNT);
  localparam logic [CNT_W-1:0] K_CNT     = CNT_W'(KEEP_COUNT);
  localparam logic [CNT_W-1:0] K_CNT_M1  = CNT_W'(KEEP_COUNT - 1);
  localparam logic [IDX_W-1:0] BUILD_TOP = IDX_W'(KEEP_COUNT / 2 - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BLD_RD,
    ST_BLD_LD,
    ST_SIFT,
    ST_FL_RD,
    ST_FL_OUT
  } state_t;

  state_t             state_r, state_nxt;
  logic [IDX_W-1:0]   node_r, node_nxt;
  logic [IDX_W-1:0]   bidx_r, bidx_nxt;
  logic [IDX_W-1:0]   fidx_r, fidx_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               bld_r, bld_nxt;
  entry_t             cur_r, cur_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_item_r, out_item_nxt;
  logic [SCORE_W-1:0] root_score_r;

  // Heap memory: one write port, two registered read ports
  entry_t             mem [KEEP_COUNT];
  entry_t             rd0_r, rd1_r;
  logic [IDX_W-1:0]   raddr0, raddr1;
  logic               we;
  logic [IDX_W-1:0]   waddr;
  entry_t             wdata;

  // Read address selection
  logic [IDX_W-1:0]   rsel_node;
  logic               rd_direct;
  logic [IDX_W-1:0]   direct_addr;
  logic [CH_W-1:0]    rs_lc, rs_rc;

  // Sift compare
  logic [CH_W-1:0]    lc, rc, mc;
  logic               has_l, has_r, pick_r;
  entry_t             min_child;
  logic               slot_free;
  logic               fl_last;

  assign slot_free = !out_valid_r || out_pop;
  assign out_empty = !out_valid_r;
  assign out_item  = out_item_r;

  // Pick the smaller child, left on a tie
  always_comb begin
    lc        = CH_W'({node_r, 1'b1});
    rc        = lc + CH_W'(1);
    has_l     = (lc < K_CH);
    has_r     = (rc < K_CH);
    pick_r    = has_r && (rd0_r.score > rd1_r.score);
    min_child = pick_r ? rd1_r : rd0_r;
    mc        = pick_r ? rc : lc;
    fl_last   = ((CNT_W'(fidx_r) + CNT_W'(1)) == count_r);
  end

  // Sequence offers, heap build, sift-down and flush
  always_comb begin
    state_nxt     = state_r;
    node_nxt      = node_r;
    bidx_nxt      = bidx_r;
    fidx_nxt      = fidx_r;
    count_nxt     = count_r;
    bld_nxt       = bld_r;
    cur_nxt       = cur_r;
    out_valid_nxt = out_valid_r && !out_pop;
    out_item_nxt  = out_item_r;
    cmd_take      = 1'b0;
    we            = 1'b0;
    waddr         = node_r;
    wdata         = cur_r;
    rsel_node     = '0;
    rd_direct     = 1'b0;
    direct_addr   = fidx_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          unique case (cmd_item.cmd)
            CMD_OFFER: begin
              cmd_take = 1'b1;
              if (count_r != K_CNT) begin
                we        = 1'b1;
                waddr     = count_r[IDX_W-1:0];
                wdata     = cmd_item.entry;
                count_nxt = count_r + CNT_W'(1);
                if (count_r == K_CNT_M1) begin
                  bld_nxt   = 1'b1;
                  bidx_nxt  = BUILD_TOP;
                  state_nxt = ST_BLD_RD;
                end
              end else if (cmd_item.entry.score > root_score_r) begin
                // Children of the root are read this cycle
                cur_nxt   = cmd_item.entry;
                node_nxt  = '0;
                bld_nxt   = 1'b0;
                state_nxt = ST_SIFT;
              end
            end
            CMD_FLUSH: begin
              if (count_r == '0) begin
                if (slot_free) begin
                  cmd_take                  = 1'b1;
                  out_valid_nxt             = 1'b1;
                  out_item_nxt.entry_offset = '0;
                  out_item_nxt.entry_score  = '0;
                  out_item_nxt.entry_valid  = 1'b0;
                  out_item_nxt.last         = 1'b1;
                end
              end else begin
                cmd_take  = 1'b1;
                fidx_nxt  = '0;
                state_nxt = ST_FL_RD;
              end
            end
          endcase
        end
      end
      ST_BLD_RD: begin
        rd_direct   = 1'b1;
        direct_addr = bidx_r;
        state_nxt   = ST_BLD_LD;
      end
      ST_BLD_LD: begin
        cur_nxt   = rd0_r;
        node_nxt  = bidx_r;
        rsel_node = bidx_r;
        state_nxt = ST_SIFT;
      end
      ST_SIFT: begin
        we    = 1'b1;
        waddr = node_r;
        if (has_l && (cur_r.score > min_child.score)) begin
          // Move the child up and descend one level
          wdata     = min_child;
          node_nxt  = mc[IDX_W-1:0];
          rsel_node = mc[IDX_W-1:0];
        end else begin
          wdata = cur_r;
          if (bld_r && (bidx_r != '0)) begin
            bidx_nxt  = bidx_r - IDX_W'(1);
            state_nxt = ST_BLD_RD;
          end else begin
            bld_nxt   = 1'b0;
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_FL_RD: begin
        rd_direct   = 1'b1;
        direct_addr = fidx_r;
        state_nxt   = ST_FL_OUT;
      end
      ST_FL_OUT: begin
        rd_direct   = 1'b1;
        direct_addr = fidx_r;
        if (slot_free) begin
          out_valid_nxt             = 1'b1;
          out_item_nxt.entry_offset = rd0_r.offset;
          out_item_nxt.entry_score  = rd0_r.score;
          out_item_nxt.entry_valid  = 1'b1;
          out_item_nxt.last         = fl_last;
          if (fl_last) begin
            count_nxt = '0;
            state_nxt = ST_IDLE;
          end else begin
            fidx_nxt  = fidx_r + IDX_W'(1);
            state_nxt = ST_FL_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Form read addresses: a direct index, or the children of a node
  always_comb begin
    rs_lc  = CH_W'({rsel_node, 1'b1});
    rs_rc  = rs_lc + CH_W'(1);
    raddr1 = (rs_rc < K_CH) ? rs_rc[IDX_W-1:0] : '0;
    if (rd_direct) begin
      raddr0 = direct_addr;
    end else begin
      raddr0 = (rs_lc < K_CH) ? rs_lc[IDX_W-1:0] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      node_r       <= '0;
      bidx_r       <= '0;
      fidx_r       <= '0;
      count_r      <= '0;
      bld_r        <= 1'b0;
      cur_r        <= '0;
      out_valid_r  <= 1'b0;
      out_item_r   <= '0;
    end else begin
      state_r      <= state_nxt;
      node_r       <= node_nxt;
      bidx_r       <= bidx_nxt;
      fidx_r       <= fidx_nxt;
      count_r      <= count_nxt;
      bld_r        <= bld_nxt;
      cur_r        <= cur_nxt;
      out_valid_r  <= out_valid_nxt;
      out_item_r   <= out_item_nxt;
    end
  end

  // Write and read the heap memory; mirror the root score
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
      if (waddr == '0) begin
        root_score_r <= wdata.score;
      end
    end
    rd0_r <= mem[raddr0];
    rd1_r <= mem[raddr1];
  end

endmodule
`default_nettype wire

[hdl/top_k_score_min_heap_core.sv]
`default_nettype none
// Keeps the ten highest-scoring (offset, score) pairs of a stream in a binary
// min-heap on score. Push mode 0 to offer a candidate, mode 1 to flush: a
// flush returns the held entries in storage order with last set on the final
// one and empties the store; a flush of an empty store returns one result
// with entry_valid low and last high. Offers return nothing. Inputs land in a
// two-deep command queue, so transactions are still taken, until it fills,
// while a result waits to be popped. In the heap engine an offer while
// filling writes the next free slot; the tenth offer then starts a bottom-up
// heap build that reads, loads and sifts down each internal node from the
// last to the root; a root replacement sifts the new entry down; a dropped
// candidate is only taken; a flush outputs each entry in turn, waiting while
// the result slot is full. The engine does one compare-and-move per cycle on
// a heap memory with one write port and two registered read ports.
module top_k_score_min_heap_core (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_push,
  output logic                     in_full,
  input  wire tksh_pkg::in_item_t  in_item,
  output logic                     out_empty,
  input  wire logic                out_pop,
  output tksh_pkg::out_item_t      out_item
);
  import tksh_pkg::*;

  logic      cmd_valid;
  logic      cmd_take;
  cmd_item_t cmd_item;

  // Accept and classify transactions
  tksh_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_item   (in_item),
    .cmd_valid (cmd_valid),
    .cmd_item  (cmd_item),
    .cmd_take  (cmd_take)
  );

  // Maintain the heap and deliver results
  tksh_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_item  (cmd_item),
    .cmd_take  (cmd_take),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire
